[hdl/hbrp_pkg.sv]
// Shared types and constants of the header block representation parser.
`default_nettype none

package hbrp_pkg;

  // Fixed field widths of the channels.
  localparam int BYTE_W      = 8;
  localparam int KIND_W      = 3;
  localparam int VALUE_W     = 32;
  localparam int MODE_W      = 2;
  localparam int ERR_W       = 2;
  localparam int TABLE_W     = 8;

  // Default width of the decoded prefix integers.
  localparam int INT_WIDTH_DEF = 32;

  // Reset value of the static table size register.
  localparam logic [TABLE_W-1:0] TABLE_ENTRIES_RST = 8'd61;

  // Kinds of result events.
  typedef enum logic [KIND_W-1:0] {
    EV_INDEXED  = 3'd0,
    EV_LITSTART = 3'd1,
    EV_STRHDR   = 3'd2,
    EV_STRBYTE  = 3'd3,
    EV_SIZEUPD  = 3'd4,
    EV_ERROR    = 3'd5
  } event_kind_t;

  // Literal indexing modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_WITH    = 2'd0,
    MODE_WITHOUT = 2'd1,
    MODE_NEVER   = 2'd2
  } index_mode_t;

  // Error codes carried by error events.
  typedef enum logic [ERR_W-1:0] {
    ERR_NONE       = 2'd0,
    ERR_INDEX_ZERO = 2'd1,
    ERR_INDEX_HIGH = 2'd2,
    ERR_OVERFLOW   = 2'd3
  } error_code_t;

endpackage

`default_nettype wire

[hdl/hbrp_in_if.sv]
// Input byte channel of the header block representation parser.
`default_nettype none

interface hbrp_in_if;
  logic                          valid;
  logic                          ready;
  logic [hbrp_pkg::BYTE_W-1:0]   in_byte;
  logic                          block_start;

  modport source (output valid, output in_byte, output block_start, input ready);
  modport sink   (input valid, input in_byte, input block_start, output ready);
endinterface

`default_nettype wire

[hdl/hbrp_out_if.sv]
// Result event channel of the header block representation parser.
`default_nettype none

interface hbrp_out_if;
  logic                          valid;
  logic                          ready;
  logic [hbrp_pkg::KIND_W-1:0]   event_kind;
  logic [hbrp_pkg::VALUE_W-1:0]  int_value;
  logic [hbrp_pkg::MODE_W-1:0]   index_mode;
  logic                          is_value_string;
  logic                          huffman_coded;
  logic [hbrp_pkg::BYTE_W-1:0]   data_byte;
  logic                          last_byte;
  logic [hbrp_pkg::ERR_W-1:0]    error_code;

  modport source (output valid, output event_kind, output int_value, output index_mode,
                  output is_value_string, output huffman_coded, output data_byte,
                  output last_byte, output error_code, input ready);
  modport sink   (input valid, input event_kind, input int_value, input index_mode,
                  input is_value_string, input huffman_coded, input data_byte,
                  input last_byte, input error_code, output ready);
endinterface

`default_nettype wire

[hdl/hbrp_cfg_if.sv]
// Configuration write channel of the header block representation parser.
`default_nettype none

interface hbrp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [hbrp_pkg::TABLE_W-1:0]  table_entries;

  modport source (output valid, output table_entries, input ready);
  modport sink   (input valid, input table_entries, output ready);
endinterface

`default_nettype wire

[hdl/header_block_representation_parser_unit.sv]
// Byte-serial parser of compressed header block representations.
// Each byte passes through the input register and then the result register.
// Throughput: one byte per cycle unless a result waits; each byte takes one logic pass.
// A byte gives at most one result; halted bytes and continuation bytes that neither
// end an integer nor overflow give none. Reset (rst_n low, synchronous) empties both
// registers, sets the table size to 61 and expects the first byte of a representation.
`default_nettype none

module header_block_representation_parser_unit #(
  parameter int INT_WIDTH = hbrp_pkg::INT_WIDTH_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  hbrp_in_if.sink      in_if,
  hbrp_out_if.source   out_if,
  hbrp_cfg_if.sink     cfg_if
);
  import hbrp_pkg::*;

  localparam int W = INT_WIDTH;
  localparam logic [6:0] SHIFT_STEP = 7'd7;
  localparam logic [6:0] SHIFT_STOP = 7'd70;

  typedef enum logic [2:0] {
    PH_FIRST    = 3'd0,
    PH_INTCONT  = 3'd1,
    PH_STRHDR   = 3'd2,
    PH_STRBYTES = 3'd3,
    PH_HALT     = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    PUR_INDEXED = 2'd0,
    PUR_NAMEIDX = 2'd1,
    PUR_STRLEN  = 2'd2,
    PUR_SIZEUPD = 2'd3
  } purpose_t;

  typedef struct packed {
    event_kind_t                kind;
    logic [VALUE_W-1:0]         value;
    index_mode_t                mode;
    logic                       is_value;
    logic                       huff;
    logic [BYTE_W-1:0]          data;
    logic                       last;
    error_code_t                err;
  } result_t;

  // Input stage.
  logic                  in_valid_r;
  logic [BYTE_W-1:0]     in_byte_r;
  logic                  in_start_r;

  // Parser state.
  phase_t                phase_r, phase_nxt;
  logic [W-1:0]          acc_r, acc_nxt;
  logic [6:0]            shift_r, shift_nxt;
  purpose_t              purpose_r, purpose_nxt;
  logic [W-1:0]          rem_r, rem_nxt;
  index_mode_t           mode_r, mode_nxt;
  logic                  is_value_r, is_value_nxt;
  logic                  huff_r, huff_nxt;
  logic [TABLE_W-1:0]    table_entries_r;

  // Result stage.
  logic                  out_valid_r;
  result_t               res_r;

  // Working signals.
  logic                  fire;
  logic                  res_valid;
  result_t               res;
  phase_t                phase_0;
  logic [W-1:0]          acc_0;
  logic [6:0]            shift_0;
  logic [W-1:0]          rem_0;
  logic                  is_value_0;
  logic                  huff_0;
  logic                  st_go;
  logic [6:0]            st_mask;
  logic [6:0]            st_v;
  purpose_t              st_purpose;
  logic                  fin_go;
  logic [W-1:0]          fin_v;
  logic [W+31:0]         fin_ext;
  logic                  fin_high;
  logic [6:0]            cont_c;
  logic [W+6:0]          add_wide;
  logic [W:0]            sum;
  logic                  ovf;

  // The stage moves when it holds a byte and the result register is free or drains.
  assign fire        = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !in_valid_r || fire;
  assign cfg_if.ready = 1'b1;

  // State as seen after an optional block start.
  assign phase_0    = in_start_r ? PH_FIRST : phase_r;
  assign acc_0      = in_start_r ? '0 : acc_r;
  assign shift_0    = in_start_r ? '0 : shift_r;
  assign rem_0      = in_start_r ? '0 : rem_r;
  assign is_value_0 = in_start_r ? 1'b0 : is_value_r;
  assign huff_0     = in_start_r ? 1'b0 : huff_r;

  // Continuation group arithmetic with overflow detection.
  assign cont_c   = in_byte_r[6:0];
  assign add_wide = {{W{1'b0}}, cont_c} << shift_0;
  assign sum      = {1'b0, acc_0} + {1'b0, add_wide[W-1:0]};
  assign ovf      = (cont_c != '0) &&
                    ((int'(shift_0) >= W) || (add_wide[W+6:W] != '0) || sum[W]);

  // Parser next state and result.
  always_comb begin
    phase_nxt    = phase_0;
    acc_nxt      = acc_0;
    shift_nxt    = shift_0;
    purpose_nxt  = purpose_r;
    rem_nxt      = rem_0;
    mode_nxt     = mode_r;
    is_value_nxt = is_value_0;
    huff_nxt     = huff_0;
    res_valid    = 1'b0;
    res          = '0;
    st_go        = 1'b0;
    st_mask      = 7'h7f;
    st_purpose   = PUR_INDEXED;
    st_v         = '0;
    fin_go       = 1'b0;
    fin_v        = '0;
    fin_ext      = '0;
    fin_high     = 1'b0;

    unique case (phase_0)
      PH_FIRST: begin
        st_go = 1'b1;
        if (in_byte_r[7]) begin
          st_mask    = 7'h7f;
          st_purpose = PUR_INDEXED;
        end else if (in_byte_r[6]) begin
          st_mask    = 7'h3f;
          st_purpose = PUR_NAMEIDX;
          mode_nxt   = MODE_WITH;
        end else if (in_byte_r[5]) begin
          st_mask    = 7'h1f;
          st_purpose = PUR_SIZEUPD;
        end else if (in_byte_r[4]) begin
          st_mask    = 7'h0f;
          st_purpose = PUR_NAMEIDX;
          mode_nxt   = MODE_NEVER;
        end else begin
          st_mask    = 7'h0f;
          st_purpose = PUR_NAMEIDX;
          mode_nxt   = MODE_WITHOUT;
        end
      end
      PH_STRHDR: begin
        huff_nxt   = in_byte_r[7];
        st_go      = 1'b1;
        st_mask    = 7'h7f;
        st_purpose = PUR_STRLEN;
      end
      PH_INTCONT: begin
        if (ovf) begin
          phase_nxt = PH_HALT;
          res_valid = 1'b1;
          res.kind  = EV_ERROR;
          res.err   = ERR_OVERFLOW;
        end else begin
          if (cont_c != '0) begin
            acc_nxt = sum[W-1:0];
          end
          shift_nxt = (shift_0 == SHIFT_STOP) ? SHIFT_STOP : shift_0 + SHIFT_STEP;
          if (!in_byte_r[7]) begin
            fin_go = 1'b1;
            fin_v  = acc_nxt;
          end
        end
      end
      PH_STRBYTES: begin
        res_valid    = 1'b1;
        res.kind     = EV_STRBYTE;
        res.mode     = mode_r;
        res.is_value = is_value_0;
        res.huff     = huff_0;
        res.data     = in_byte_r;
        res.last     = (rem_0[W-1:1] == '0);
        if (res.last) begin
          rem_nxt      = '0;
          phase_nxt    = is_value_0 ? PH_FIRST : PH_STRHDR;
          is_value_nxt = 1'b1;
        end else begin
          rem_nxt = rem_0 - W'(1);
        end
      end
      default: begin
        phase_nxt = PH_HALT;
      end
    endcase

    // Prefix integer: done at once unless the prefix is all ones.
    if (st_go) begin
      purpose_nxt = st_purpose;
      st_v        = in_byte_r[6:0] & st_mask;
      if (st_v != st_mask) begin
        fin_go = 1'b1;
        fin_v  = W'(st_v);
      end else begin
        acc_nxt   = W'(st_v);
        shift_nxt = '0;
        phase_nxt = PH_INTCONT;
      end
    end

    // A finished integer is used according to what it encodes.
    if (fin_go) begin
      // The finished integer is cut to the result width and compared with the table size.
      fin_ext   = {32'b0, fin_v};
      fin_high  = fin_v > {{(W-TABLE_W){1'b0}}, table_entries_r};
      res_valid = 1'b1;
      res.value = fin_ext[VALUE_W-1:0];
      unique case (purpose_nxt)
        PUR_INDEXED: begin
          phase_nxt = PH_FIRST;
          if (fin_v == '0) begin
            phase_nxt = PH_HALT;
            res.kind  = EV_ERROR;
            res.err   = ERR_INDEX_ZERO;
          end else if (fin_high) begin
            phase_nxt = PH_HALT;
            res.kind  = EV_ERROR;
            res.err   = ERR_INDEX_HIGH;
          end else begin
            res.kind = EV_INDEXED;
          end
        end
        PUR_NAMEIDX: begin
          if (fin_high) begin
            phase_nxt = PH_HALT;
            res.kind  = EV_ERROR;
            res.err   = ERR_INDEX_HIGH;
          end else begin
            is_value_nxt = (fin_v != '0);
            phase_nxt    = PH_STRHDR;
            res.kind     = EV_LITSTART;
            res.mode     = mode_nxt;
          end
        end
        PUR_STRLEN: begin
          res.kind     = EV_STRHDR;
          res.mode     = mode_nxt;
          res.is_value = is_value_0;
          res.huff     = huff_nxt;
          if (fin_v == '0) begin
            phase_nxt    = is_value_0 ? PH_FIRST : PH_STRHDR;
            is_value_nxt = 1'b1;
          end else begin
            rem_nxt   = fin_v;
            phase_nxt = PH_STRBYTES;
          end
        end
        default: begin
          phase_nxt = PH_FIRST;
          res.kind  = EV_SIZEUPD;
        end
      endcase
    end
  end

  // Input register, parser state, result register and table size.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      phase_r         <= PH_FIRST;
      acc_r           <= '0;
      shift_r         <= '0;
      purpose_r       <= PUR_INDEXED;
      rem_r           <= '0;
      mode_r          <= MODE_WITH;
      is_value_r      <= 1'b0;
      huff_r          <= 1'b0;
      table_entries_r <= TABLE_ENTRIES_RST;
    end else begin
      if (in_if.ready) begin
        in_valid_r <= in_if.valid;
      end
      if (fire) begin
        out_valid_r <= res_valid;
        phase_r     <= phase_nxt;
        acc_r       <= acc_nxt;
        shift_r     <= shift_nxt;
        purpose_r   <= purpose_nxt;
        rem_r       <= rem_nxt;
        mode_r      <= mode_nxt;
        is_value_r  <= is_value_nxt;
        huff_r      <= huff_nxt;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_if.valid) begin
        table_entries_r <= cfg_if.table_entries;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      in_byte_r  <= in_if.in_byte;
      in_start_r <= in_if.block_start;
    end
    if (fire) begin
      res_r <= res;
    end
  end

  // Result channel.
  assign out_if.valid           = out_valid_r;
  assign out_if.event_kind      = res_r.kind;
  assign out_if.int_value       = res_r.value;
  assign out_if.index_mode      = res_r.mode;
  assign out_if.is_value_string = res_r.is_value;
  assign out_if.huffman_coded   = res_r.huff;
  assign out_if.data_byte       = res_r.data;
  assign out_if.last_byte       = res_r.last;
  assign out_if.error_code      = res_r.err;

`ifndef ASSERT_OFF
  // A halted parser stays silent for bytes without a block start.
  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (phase_r == PH_HALT) && !in_start_r |=> !out_valid_r)
    else $error("result produced while halted");

  // Every error event carries an error code.
  a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.kind == EV_ERROR) |-> (res_r.err != ERR_NONE))
    else $error("error event without code");

  // An error always halts the parser.
  a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_valid && (res.kind == EV_ERROR) |=> (phase_r == PH_HALT))
    else $error("parser did not halt after error");

  // While string bytes are expected, at least one remains.
  a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_STRBYTES) |-> (rem_r != '0))
    else $error("string byte phase with no bytes remaining");

  // The continuation shift never passes its stop value.
  a_shift_cap: assert property (@(posedge clk) disable iff (!rst_n)
    shift_r <= SHIFT_STOP)
    else $error("continuation shift out of range");
`endif

endmodule

`default_nettype wire
